[hw/rtl/itpe_pkg.sv]
// ----------------------------------------------------------------------------
// itpe_pkg
// Shared types, constants and color helpers for the indexed texture palette
// expander.
// ----------------------------------------------------------------------------
package itpe_pkg;

   // Palette size default (entries of 32 bits)
   localparam int DEF_PALETTE_ENTRIES = 256;

   // Response queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Alpha doubling saturates above this value
   localparam logic [7:0] ALPHA_SAT_LIMIT = 8'd127;
   localparam logic [7:0] ALPHA_OPAQUE    = 8'd255;

   // Transaction kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Pixel modes
   typedef enum logic [1:0] {
      MODE_DIRECT = 2'd0,
      MODE_GREY   = 2'd1,
      MODE_IDX8   = 2'd2,
      MODE_IDX4   = 2'd3
   } mode_type;

   // One response entry
   typedef struct packed {
      logic [31:0] rgba;
      logic        last;
   } rsp_entry_type;

   // Double alpha, saturate to opaque
   function automatic logic [31:0] fix_alpha(input logic [31:0] w);
      logic [7:0] a;
      a = w[31:24];
      if (a > ALPHA_SAT_LIMIT) begin
         a = ALPHA_OPAQUE;
      end else begin
         a = {a[6:0], 1'b0};
      end
      return {a, w[23:0]};
   endfunction

   // Greyscale byte into R, G, B with opaque alpha
   function automatic logic [31:0] grey_expand(input logic [7:0] b);
      return {ALPHA_OPAQUE, b, b, b};
   endfunction

   // Block reorder for eight-bit index loads: exchange bits 3 and 4
   function automatic logic [7:0] swap_bits34(input logic [7:0] p);
      return {p[7:5], p[3], p[4], p[2:0]};
   endfunction

endpackage

[hw/rtl/itpe_palette_ram.sv]
// ----------------------------------------------------------------------------
// itpe_palette_ram
// Palette store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module itpe_palette_ram
   import itpe_pkg::*;
#(
   parameter int ENTRIES = DEF_PALETTE_ENTRIES
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
   input  logic [31:0]                  wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(ENTRIES)-1:0]   rd_addr_a,
   input  logic [$clog2(ENTRIES)-1:0]   rd_addr_b,
   output logic [31:0]                  rd_data_a,
   output logic [31:0]                  rd_data_b
);

   logic [31:0] mem [ENTRIES];
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two read ports, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hw/rtl/itpe_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// itpe_rsp_fifo
// Small response queue; takes up to two entries per cycle, gives one.
// ----------------------------------------------------------------------------
module itpe_rsp_fifo
   import itpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  rsp_entry_type         push0,
   input  rsp_entry_type         push1,
   input  logic                  pop,
   output rsp_entry_type         head,
   output logic                  not_empty,
   output logic [RSP_CNT_W-1:0]  count
);

   rsp_entry_type         mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0]  wr_ptr_nxt;

   assign wr_ptr_nxt = wr_ptr_ff + RSP_PTR_W'(1);

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem[wr_ptr_nxt] <= push1;
      end
   end

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      cnt_in    = cnt_ff + RSP_CNT_W'(push_cnt) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign head      = mem[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule

[hw/rtl/indexed_texture_palette_expander.sv]
// ----------------------------------------------------------------------------
// indexed_texture_palette_expander
// Expands texture pixels to 32-bit RGBA words through a palette store.
// ----------------------------------------------------------------------------
// Each transaction is either a palette load or a pixel. Loads write one entry
// (alpha doubled, saturating, if in range) at the accept edge; no response.
// Pixels are expanded by the pixel mode: direct, greyscale, 8-bit index or
// 4-bit index (two responses, low nibble first, the second flagged last).
// A new transaction can be taken every cycle while the response queue has
// room for all in flight plus two; direct, greyscale, 8-bit index and load
// transactions sustain one per cycle, 4-bit index ones less, set by the
// single response port. Pixels pass stage 1, then the response queue. The
// palette RAM has two read ports so both nibbles are looked up together; its
// contents are not cleared at reset and entries must be loaded before they
// are looked up. Write the pixel mode only while no transaction is in flight.
// ----------------------------------------------------------------------------
module indexed_texture_palette_expander
   import itpe_pkg::*;
#(
   parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_kind,
   input  logic [7:0]   req_entry_position,
   input  logic [31:0]  req_value,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [31:0]  rsp_pixel_rgba,
   output logic         rsp_last,
   // configuration
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   mode_type               mode_ff;
   logic                   in_acc;
   logic [7:0]             wr_pos;
   logic                   wr_hit;
   logic [AW-1:0]          rd_addr_a;
   logic [AW-1:0]          rd_addr_b;
   logic [31:0]            rd_data_a;
   logic [31:0]            rd_data_b;

   logic                   s1_valid_ff, s1_valid_in;
   mode_type               s1_mode_ff;
   logic [31:0]            s1_value_ff;
   logic                   s1_hit_ff;
   logic [1:0]             s1_n;

   rsp_entry_type          push0, push1, head;
   logic                   fifo_not_empty;
   logic [RSP_CNT_W-1:0]   fifo_count;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIRECT;
      end else if (csr_we) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   // Credit check: room for everything queued or in flight plus two more
   assign req_ready = ((RSP_CNT_W+1)'(fifo_count) + (RSP_CNT_W+1)'(s1_n))
                      <= (RSP_CNT_W+1)'(RSP_DEPTH - 2);
   assign in_acc    = req_valid && req_ready;

   // Load address: block reorder in 8-bit index mode, drop out-of-range
   assign wr_pos = (mode_ff == MODE_IDX8) ? swap_bits34(req_entry_position)
                                          : req_entry_position;
   assign wr_hit = ({1'b0, wr_pos} < 9'(PALETTE_ENTRIES));

   // Lookup addresses
   assign rd_addr_a = (mode_ff == MODE_IDX4) ? AW'(req_value[3:0])
                                             : req_value[AW-1:0];
   assign rd_addr_b = AW'(req_value[7:4]);

   itpe_palette_ram #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock     (clock),
      .wr_en     (in_acc && (req_kind == KIND_LOAD) && wr_hit),
      .wr_addr   (wr_pos[AW-1:0]),
      .wr_data   (fix_alpha(req_value)),
      .rd_en     (in_acc && (req_kind == KIND_PIXEL)),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Stage 1: pixel in flight alongside the RAM read
   assign s1_valid_in = in_acc && (req_kind == KIND_PIXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_mode_ff  <= mode_ff;
         s1_value_ff <= req_value;
         s1_hit_ff   <= ({1'b0, req_value[7:0]} < 9'(PALETTE_ENTRIES));
      end
   end

   // Response formation
   always_comb begin
      push0 = '{rgba: s1_value_ff, last: 1'b1};
      push1 = '{rgba: rd_data_b, last: 1'b1};
      unique case (s1_mode_ff)
         MODE_DIRECT: push0 = '{rgba: s1_value_ff, last: 1'b1};
         MODE_GREY:   push0 = '{rgba: grey_expand(s1_value_ff[7:0]), last: 1'b1};
         MODE_IDX8:   push0 = '{rgba: (s1_hit_ff ? rd_data_a : 32'd0), last: 1'b1};
         MODE_IDX4:   push0 = '{rgba: rd_data_a, last: 1'b0};
         default:     push0 = '{rgba: s1_value_ff, last: 1'b1};
      endcase
   end

   assign s1_n = !s1_valid_ff ? 2'd0 : ((s1_mode_ff == MODE_IDX4) ? 2'd2 : 2'd1);

   itpe_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (s1_n),
      .push0     (push0),
      .push1     (push1),
      .pop       (rsp_valid && rsp_ready),
      .head      (head),
      .not_empty (fifo_not_empty),
      .count     (fifo_count)
   );

   assign rsp_valid      = fifo_not_empty;
   assign rsp_pixel_rgba = head.rgba;
   assign rsp_last       = head.last;

endmodule

[hw/rtl/itpe_checker.sv]
// ----------------------------------------------------------------------------
// itpe_port_checks
// Port-level checks for the palette expander, bound to the top level.
// ----------------------------------------------------------------------------
module itpe_port_checks
   import itpe_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [31:0]  rsp_pixel_rgba,
   input logic         rsp_last
);

   // Response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_rgba) && $stable(rsp_last))
      else $error("response dropped or changed while stalled");

   // Queue empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Second half of a 4-bit index pair is ready right behind the first
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("missing second response of a pair");

   // Requests only back up when responses are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with nothing to deliver");

endmodule

bind indexed_texture_palette_expander itpe_port_checks u_itpe_port_checks (.*);

[dv/itpe_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itpe_checker
// Watches the request, response and configuration ports of the palette
// expander, predicts every expanded pixel from its own copy of the palette
// and pixel mode, and compares each response field against the oldest
// prediction. Mismatches and unexpected responses are counted.
// ----------------------------------------------------------------------------
module itpe_checker
   import itpe_pkg::*;
#(
   parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  logic         req_kind,
   input  logic [7:0]   req_entry_position,
   input  logic [31:0]  req_value,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  logic [31:0]  rsp_pixel_rgba,
   input  logic         rsp_last,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,
   output int           error_count,
   output int           pending_count
);

   // Shadow state of the block
   mode_type      pixel_mode_q;
   logic [31:0]   palette_mem [PALETTE_ENTRIES];
   rsp_entry_type expected_pixels [$];
   rsp_entry_type oldest;
   int            mismatch_total = 0;

   // Palette read; positions past the store read as zero
   function automatic logic [31:0] palette_read(input logic [7:0] idx);
      if (idx >= PALETTE_ENTRIES) begin
         return 32'h0;
      end
      return palette_mem[idx];
   endfunction

   // Palette load: alpha doubled with saturation, 8-bit index mode reorders
   task automatic store_entry(input logic [7:0] pos, input logic [31:0] word);
      logic [7:0] slot;
      logic [7:0] alpha;
      slot = pos;
      if (pixel_mode_q == MODE_IDX8) begin
         slot = {pos[7:5], pos[3], pos[4], pos[2:0]};
      end
      alpha = word[31:24];
      alpha = (alpha > 8'd127) ? 8'd255 : (alpha << 1);
      if (slot < PALETTE_ENTRIES) begin
         palette_mem[slot] = {alpha, word[23:0]};
      end
   endtask

   // Expected pixels for one pixel transaction
   task automatic predict_pixels(input logic [31:0] word);
      logic [7:0] b;
      b = word[7:0];
      case (pixel_mode_q)
         MODE_GREY: begin
            expected_pixels.push_back('{rgba: {8'd255, b, b, b}, last: 1'b1});
         end
         MODE_IDX8: begin
            expected_pixels.push_back('{rgba: palette_read(b), last: 1'b1});
         end
         MODE_IDX4: begin
            expected_pixels.push_back('{rgba: palette_read({4'h0, b[3:0]}), last: 1'b0});
            expected_pixels.push_back('{rgba: palette_read({4'h0, b[7:4]}), last: 1'b1});
         end
         default: begin
            expected_pixels.push_back('{rgba: word, last: 1'b1});
         end
      endcase
   endtask

   // Responses are checked before new requests are predicted at the same edge
   always @(posedge clock) begin
      if (reset) begin
         pixel_mode_q = MODE_DIRECT;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual rgba %08h last %0b",
                        $time, rsp_pixel_rgba, rsp_last);
               mismatch_total++;
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_pixel_rgba !== oldest.rgba) begin
                  $display("%0t: pixel_rgba mismatch: expected %08h, actual %08h",
                           $time, oldest.rgba, rsp_pixel_rgba);
                  mismatch_total++;
               end
               if (rsp_last !== oldest.last) begin
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, oldest.last, rsp_last);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               store_entry(req_entry_position, req_value);
            end else begin
               predict_pixels(req_value);
            end
         end
         if (csr_we) begin
            pixel_mode_q = mode_type'(csr_wdata);
         end
      end
      pending_count <= expected_pixels.size();
      error_count   <= mismatch_total;
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the indexed texture palette expander.
// ----------------------------------------------------------------------------
// A directed pass covers pass-through extremes, greyscale, alpha saturation,
// the bit 3/4 reorder of 8-bit index loads and both nibble lookups. Random
// phases then step through the pixel modes with mixed loads and pixels; index
// pixels only look up palette entries already loaded. Both channels idle at
// random, except for one phase that runs at full rate.
// ----------------------------------------------------------------------------
module testbench;
   import itpe_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   logic         req_kind = KIND_LOAD;
   logic [7:0]   req_entry_position = 8'h00;
   logic [31:0]  req_value = 32'h0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   logic [31:0]  rsp_pixel_rgba;
   logic         rsp_last;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_wdata = MODE_DIRECT;

   int           fail_total;
   int           pending_total;

   // Stimulus-side view of what the palette holds
   mode_type     cur_mode = MODE_DIRECT;
   logic [255:0] is_loaded = '0;
   logic [7:0]   loaded_slots [$];
   logic [3:0]   low_slots [$];
   logic         calm = 1'b0;
   logic [7:0]   alpha_edges [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
   logic [31:0]  word;
   mode_type     phase_mode;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   indexed_texture_palette_expander u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_entry_position (req_entry_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_rgba     (rsp_pixel_rgba),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   itpe_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_entry_position (req_entry_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_rgba     (rsp_pixel_rgba),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .error_count        (fail_total),
      .pending_count      (pending_total)
   );

   // Response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 38);
      end
   end

   // One request transaction, with random idle cycles ahead of it
   task automatic issue_txn(input logic kind, input logic [7:0] pos,
                            input logic [31:0] val);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_entry_position <= pos;
      req_value          <= val;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Palette load; remembers which slot it lands in under the current mode
   task automatic load_color(input logic [7:0] pos, input logic [31:0] val);
      logic [7:0] slot;
      slot = (cur_mode == MODE_IDX8) ? {pos[7:5], pos[3], pos[4], pos[2:0]} : pos;
      if (!is_loaded[slot]) begin
         is_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
         if (slot < 16) begin
            low_slots.push_back(slot[3:0]);
         end
      end
      issue_txn(KIND_LOAD, pos, val);
   endtask

   // Drain: stop requesting and wait until nothing is outstanding
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_mode(input mode_type m);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      cur_mode = m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Nibble whose palette entry is known to be loaded
   function automatic logic [3:0] pick_nibble();
      logic [3:0] n;
      n = 4'($urandom_range(15));
      if (!is_loaded[n]) begin
         n = low_slots[$urandom_range(low_slots.size() - 1)];
      end
      return n;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Direct mode: pass-through extremes, loads with alpha edge cases
      apply_mode(MODE_DIRECT);
      load_color(8'h00, 32'h00112233);
      load_color(8'h0F, 32'h7F445566);
      load_color(8'hFF, 32'h80778899);
      issue_txn(KIND_PIXEL, 8'hFF, 32'h00000000);
      issue_txn(KIND_PIXEL, 8'h00, 32'hFFFFFFFF);

      // Greyscale, upper value bits ignored
      apply_mode(MODE_GREY);
      issue_txn(KIND_PIXEL, 8'h00, 32'h00000000);
      issue_txn(KIND_PIXEL, 8'h00, 32'h000000FF);
      issue_txn(KIND_PIXEL, 8'hA5, 32'hABCDEF5A);

      // 8-bit index: loads exchange position bits 3 and 4
      apply_mode(MODE_IDX8);
      load_color(8'h08, 32'hFFA5A5A5);
      load_color(8'h10, 32'h01C3C3C3);
      load_color(8'hF7, 32'h3C0F0F0F);
      issue_txn(KIND_PIXEL, 8'h00, 32'hFFFFFF10);
      issue_txn(KIND_PIXEL, 8'h00, 32'h00000008);
      issue_txn(KIND_PIXEL, 8'h00, 32'h000000EF);
      issue_txn(KIND_PIXEL, 8'h00, 32'h123456FF);

      // 4-bit index: two lookups, low nibble first; load without reorder
      apply_mode(MODE_IDX4);
      load_color(8'h09, 32'h40102030);
      issue_txn(KIND_PIXEL, 8'h00, 32'h000000F0);
      issue_txn(KIND_PIXEL, 8'h00, 32'hFFFFFF0F);
      issue_txn(KIND_PIXEL, 8'h00, 32'h0000009F);
      issue_txn(KIND_PIXEL, 8'h00, 32'h00000089);

      // Random phases over all modes; one phase without idling
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0:       phase_mode = MODE_IDX4;
            1:       phase_mode = MODE_DIRECT;
            2:       phase_mode = MODE_GREY;
            3:       phase_mode = MODE_IDX8;
            default: phase_mode = mode_type'(2'($urandom_range(3)));
         endcase
         apply_mode(phase_mode);
         calm <= (ph == 5);
         for (int n = 0; n < 138; n++) begin
            word = $urandom;
            if ($urandom_range(99) < 25) begin
               if ($urandom_range(3) == 0) begin
                  word[31:24] = alpha_edges[$urandom_range(3)];
               end
               load_color(8'($urandom_range(255)), word);
            end else begin
               case (cur_mode)
                  MODE_IDX8: begin
                     if (!is_loaded[word[7:0]]) begin
                        word[7:0] = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
                     end
                  end
                  MODE_IDX4: begin
                     word[7:0] = {pick_nibble(), pick_nibble()};
                  end
                  MODE_DIRECT: begin
                     if ($urandom_range(15) == 0) begin
                        word = $urandom_range(1) ? 32'hFFFFFFFF : 32'h00000000;
                     end
                  end
                  default: ;
               endcase
               issue_txn(KIND_PIXEL, 8'($urandom_range(255)), word);
            end
         end
      end

      calm <= 1'b0;
      settle();
      if (fail_total == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[files.f]
hw/rtl/itpe_pkg.sv
hw/rtl/itpe_palette_ram.sv
hw/rtl/itpe_rsp_fifo.sv
hw/rtl/indexed_texture_palette_expander.sv
hw/rtl/itpe_checker.sv
dv/itpe_checker.sv
dv/testbench.sv
